/* sv/iosj_pkg.sv */
// shared constants and types for the interval overlap sweep join
package iosj_pkg;

  // default sizing of the two windows and of the index fields
  localparam int unsigned WINDOW_DEPTH_DEF = 32;
  localparam int unsigned INDEX_BITS_DEF   = 24;

  // width of an interval position
  localparam int unsigned POS_W = 32;

  // control half of a result request from the sweep controller
  typedef struct packed {
    logic valid;
    logic last;
  } push_ctl_t;

endpackage

/* sv/iosj_win_mem.sv */
// synchronous window memory, one write port and one registered read port
module iosj_win_mem #(
  parameter int unsigned ADDR_W = 6,
  parameter int unsigned DATA_W = 88
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [2**ADDR_W];
  logic [DATA_W-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/iosj_sweep_ctrl.sv */
// sweep controller: walks and compacts the other window, then appends the item
module iosj_sweep_ctrl #(
  parameter int unsigned WINDOW_DEPTH = iosj_pkg::WINDOW_DEPTH_DEF,
  parameter int unsigned INDEX_BITS   = iosj_pkg::INDEX_BITS_DEF,
  parameter int unsigned AW           = $clog2(WINDOW_DEPTH),
  parameter int unsigned EW           = 2 * iosj_pkg::POS_W + INDEX_BITS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // input request
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [iosj_pkg::POS_W-1:0]   interval_start_i,
  input  logic [iosj_pkg::POS_W-1:0]   interval_stop_i,
  input  logic                         set_select_i,
  input  logic [INDEX_BITS-1:0]        item_index_i,
  input  logic                         restart_i,
  // memory side
  output logic                         mem_we_o,
  output logic [AW:0]                  mem_waddr_o,
  output logic [EW-1:0]                mem_wdata_o,
  output logic                         mem_re_o,
  output logic [AW:0]                  mem_raddr_o,
  input  logic [EW-1:0]                mem_rdata_i,
  // result request to the output stage
  input  logic                         out_free_i,
  output iosj_pkg::push_ctl_t          push_o,
  output logic [INDEX_BITS-1:0]        push_first_o,
  output logic [INDEX_BITS-1:0]        push_second_o,
  output logic                         push_ovf_o
);
  import iosj_pkg::*;

  localparam int unsigned CW = $clog2(WINDOW_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(WINDOW_DEPTH);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_WALK   = 2'd1;
  localparam logic [1:0] ST_APPEND = 2'd2;
  localparam logic [1:0] ST_FLUSH  = 2'd3;

  logic [1:0]            state_q, state_d;
  logic [POS_W-1:0]      start_q, start_d;
  logic [POS_W-1:0]      stop_q, stop_d;
  logic                  sel_q, sel_d;
  logic [INDEX_BITS-1:0] idx_q, idx_d;
  logic [CW-1:0]         cnt0_q, cnt0_d;
  logic [CW-1:0]         cnt1_q, cnt1_d;
  logic                  ovf_q, ovf_d;
  logic [CW-1:0]         n_q, n_d;
  logic [CW-1:0]         rptr_q, rptr_d;
  logic [CW-1:0]         wptr_q, wptr_d;
  logic                  rvld_q, rvld_d;
  logic                  pend_q, pend_d;
  logic [INDEX_BITS-1:0] pend_idx_q, pend_idx_d;

  logic [POS_W-1:0]      g_start, g_stop, hi, lo;
  logic [INDEX_BITS-1:0] g_idx;
  logic                  keep, ovl, stall;
  logic [CW-1:0]         base0, base1, own_base, own_cnt;
  logic                  base_ovf;
  logic                  push_last;
  logic [INDEX_BITS-1:0] push_oth;

  // fields of the entry held in the read register
  assign g_start = mem_rdata_i[EW-1 -: POS_W];
  assign g_stop  = mem_rdata_i[INDEX_BITS +: POS_W];
  assign g_idx   = mem_rdata_i[INDEX_BITS-1:0];

  // removal and overlap tests
  assign keep  = !(g_stop < start_q);
  assign hi    = (g_stop < stop_q) ? g_stop : stop_q;
  assign lo    = (g_start > start_q) ? g_start : start_q;
  assign ovl   = keep && (hi >= lo);
  assign stall = rvld_q && ovl && pend_q && !out_free_i;

  // window state after an optional restart
  assign base0    = restart_i ? '0 : cnt0_q;
  assign base1    = restart_i ? '0 : cnt1_q;
  assign base_ovf = restart_i ? 1'b0 : ovf_q;
  assign own_base = set_select_i ? base1 : base0;
  assign own_cnt  = sel_q ? cnt1_q : cnt0_q;

  assign in_ready_o = (state_q == ST_IDLE);

  // next state and datapath control
  always_comb begin
    state_d     = state_q;
    start_d     = start_q;
    stop_d      = stop_q;
    sel_d       = sel_q;
    idx_d       = idx_q;
    cnt0_d      = cnt0_q;
    cnt1_d      = cnt1_q;
    ovf_d       = ovf_q;
    n_d         = n_q;
    rptr_d      = rptr_q;
    wptr_d      = wptr_q;
    rvld_d      = rvld_q;
    pend_d      = pend_q;
    pend_idx_d  = pend_idx_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = {~sel_q, wptr_q[AW-1:0]};
    mem_wdata_o = mem_rdata_i;
    mem_re_o    = 1'b0;
    mem_raddr_o = {~sel_q, rptr_q[AW-1:0]};
    push_o      = '0;
    push_last   = 1'b0;
    push_oth    = pend_idx_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          start_d = interval_start_i;
          stop_d  = interval_stop_i;
          sel_d   = set_select_i;
          idx_d   = item_index_i;
          cnt0_d  = base0;
          cnt1_d  = base1;
          ovf_d   = base_ovf | (own_base == DEPTH_C);
          n_d     = set_select_i ? base0 : base1;
          rptr_d  = '0;
          wptr_d  = '0;
          rvld_d  = 1'b0;
          pend_d  = 1'b0;
          state_d = ST_WALK;
        end
      end
      ST_WALK: begin
        if (!stall) begin
          // consume the entry held in the read register
          if (rvld_q) begin
            if (keep) begin
              mem_we_o = 1'b1;
              wptr_d   = wptr_q + CW'(1);
            end
            if (ovl) begin
              pend_d     = 1'b1;
              pend_idx_d = g_idx;
              push_o.valid = pend_q;
            end
          end
          // issue the next read or finish the walk
          if (rptr_q < n_q) begin
            mem_re_o = 1'b1;
            rptr_d   = rptr_q + CW'(1);
            rvld_d   = 1'b1;
          end else begin
            rvld_d  = 1'b0;
            state_d = ST_APPEND;
            if (sel_q) begin
              cnt0_d = wptr_d;
            end else begin
              cnt1_d = wptr_d;
            end
          end
        end
      end
      ST_APPEND: begin
        // store the item in its own window when there is room
        if (own_cnt != DEPTH_C) begin
          mem_we_o    = 1'b1;
          mem_waddr_o = {sel_q, own_cnt[AW-1:0]};
          mem_wdata_o = {start_q, stop_q, idx_q};
          if (sel_q) begin
            cnt1_d = cnt1_q + CW'(1);
          end else begin
            cnt0_d = cnt0_q + CW'(1);
          end
        end
        if (pend_q && out_free_i) begin
          push_o.valid = 1'b1;
          push_last    = 1'b1;
          pend_d       = 1'b0;
          state_d      = ST_IDLE;
        end else if (pend_q) begin
          state_d = ST_FLUSH;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_FLUSH: begin
        if (out_free_i) begin
          push_o.valid = 1'b1;
          push_last    = 1'b1;
          pend_d       = 1'b0;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    push_o.last = push_last;
  end

  // pair order follows the set of the incoming item
  assign push_first_o  = sel_q ? push_oth : idx_q;
  assign push_second_o = sel_q ? idx_q : push_oth;
  assign push_ovf_o    = ovf_q;

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt0_q  <= '0;
      cnt1_q  <= '0;
      ovf_q   <= 1'b0;
      rvld_q  <= 1'b0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt0_q  <= cnt0_d;
      cnt1_q  <= cnt1_d;
      ovf_q   <= ovf_d;
      rvld_q  <= rvld_d;
      pend_q  <= pend_d;
    end
  end

  // item and pointer registers
  always_ff @(posedge clk_i) begin
    start_q    <= start_d;
    stop_q     <= stop_d;
    sel_q      <= sel_d;
    idx_q      <= idx_d;
    n_q        <= n_d;
    rptr_q     <= rptr_d;
    wptr_q     <= wptr_d;
    pend_idx_q <= pend_idx_d;
  end

endmodule

/* sv/interval_overlap_sweep_join_unit.sv */
// top level of the interval overlap sweep join
//
// Input channel: one closed interval per request, tagged with its set, index
// and restart bit; intervals must arrive in nondecreasing start order (not enforced).
// Output channel: one request per overlapping (first index, second index)
// pair, with last_pair on the final pair of an item and the sticky overflow
// flag as it stands after that item's append.
// After acceptance the block walks the other set's window entry by entry
// through the single read port of the window memory, drains its read
// register, appends the item and hands over any last pair before it is
// ready again; an item that makes no pair walks the whole window as well.
// Pairs leave one pair behind the walk so that the last one can be marked.
// Reset empties both windows and clears the overflow flag; the window
// memory itself is not cleared. A stalled receiver holds the output
// register, and the walk stops at the next overlapping entry until the
// register frees up; no pair is dropped.
module interval_overlap_sweep_join_unit #(
  parameter int unsigned WINDOW_DEPTH = iosj_pkg::WINDOW_DEPTH_DEF,
  parameter int unsigned INDEX_BITS   = iosj_pkg::INDEX_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [iosj_pkg::POS_W-1:0] interval_start_i,
  input  logic [iosj_pkg::POS_W-1:0] interval_stop_i,
  input  logic                       set_select_i,
  input  logic [INDEX_BITS-1:0]      item_index_i,
  input  logic                       restart_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [INDEX_BITS-1:0]      first_index_o,
  output logic [INDEX_BITS-1:0]      second_index_o,
  output logic                       last_pair_o,
  output logic                       window_overflow_o
);
  import iosj_pkg::*;

  localparam int unsigned AW = $clog2(WINDOW_DEPTH);
  localparam int unsigned EW = 2 * POS_W + INDEX_BITS;

  logic                  mem_we, mem_re;
  logic [AW:0]           mem_waddr, mem_raddr;
  logic [EW-1:0]         mem_wdata, mem_rdata;
  push_ctl_t             push;
  logic [INDEX_BITS-1:0] push_first, push_second;
  logic                  push_ovf;
  logic                  out_free;

  logic                  out_valid_q;
  logic [INDEX_BITS-1:0] first_q, second_q;
  logic                  last_q, ovf_q;

  // both windows share one memory, the set bit selects the half
  iosj_win_mem #(
    .ADDR_W (AW + 1),
    .DATA_W (EW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  iosj_sweep_ctrl #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .INDEX_BITS   (INDEX_BITS),
    .AW           (AW),
    .EW           (EW)
  ) u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .interval_start_i (interval_start_i),
    .interval_stop_i  (interval_stop_i),
    .set_select_i     (set_select_i),
    .item_index_i     (item_index_i),
    .restart_i        (restart_i),
    .mem_we_o         (mem_we),
    .mem_waddr_o      (mem_waddr),
    .mem_wdata_o      (mem_wdata),
    .mem_re_o         (mem_re),
    .mem_raddr_o      (mem_raddr),
    .mem_rdata_i      (mem_rdata),
    .out_free_i       (out_free),
    .push_o           (push),
    .push_first_o     (push_first),
    .push_second_o    (push_second),
    .push_ovf_o       (push_ovf)
  );

  // output register
  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (push.valid) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push.valid) begin
      first_q  <= push_first;
      second_q <= push_second;
      last_q   <= push.last;
      ovf_q    <= push_ovf;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign first_index_o     = first_q;
  assign second_index_o    = second_q;
  assign last_pair_o       = last_q;
  assign window_overflow_o = ovf_q;

endmodule

/* sv/iosj_checker.sv */
// port level checks for the interval overlap sweep join
module iosj_checker #(
  parameter int unsigned INDEX_BITS = iosj_pkg::INDEX_BITS_DEF
) (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_o,
  input logic [iosj_pkg::POS_W-1:0] interval_start_i,
  input logic [iosj_pkg::POS_W-1:0] interval_stop_i,
  input logic                       set_select_i,
  input logic [INDEX_BITS-1:0]      item_index_i,
  input logic                       restart_i,
  input logic                       out_valid_o,
  input logic                       out_ready_i,
  input logic [INDEX_BITS-1:0]      first_index_o,
  input logic [INDEX_BITS-1:0]      second_index_o,
  input logic                       last_pair_o,
  input logic                       window_overflow_o
);

  // a waiting request holds its payload
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(interval_start_i)
      && $stable(interval_stop_i) && $stable(set_select_i)
      && $stable(item_index_i) && $stable(restart_i))
    else $error("request changed while waiting");

  // a stalled result holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(first_index_o)
      && $stable(second_index_o) && $stable(last_pair_o)
      && $stable(window_overflow_o))
    else $error("result changed while stalled");

  // one item at a time: the block is busy right after taking a request
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request taken while busy");

  // a pair that is not the last leaves the item still in flight
  a_busy_before_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_pair_o |-> !in_ready_o)
    else $error("ready before the last pair of an item");

  // results are made only while an item is being worked on
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result appeared while idle");

endmodule

bind interval_overlap_sweep_join_unit iosj_checker #(
  .INDEX_BITS (INDEX_BITS)
) u_iosj_checker (.*);
